// File: rtl/pbwfp_pkg.sv
`default_nettype none

package pbwfp_pkg;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_SCALAR  = 3'd0,
		KIND_LEN_HDR = 3'd1,
		KIND_PAYLOAD = 3'd2,
		KIND_UNKNOWN = 3'd3,
		KIND_ERROR   = 3'd4,
		KIND_END     = 3'd5
	} kind_t;

	// Error codes carried by error results.
	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_VARINT_OVF  = 3'd1,
		ERR_SHORT_FIX64 = 3'd2,
		ERR_SHORT_PAYLD = 3'd3,
		ERR_SHORT_FIX32 = 3'd4
	} err_t;

	// Parser phases, one-hot.
	typedef enum logic [6:0] {
		PH_TAG     = 7'b0000001,
		PH_VAL     = 7'b0000010,
		PH_FIX64   = 7'b0000100,
		PH_LEN     = 7'b0001000,
		PH_PAYLOAD = 7'b0010000,
		PH_FIX32   = 7'b0100000,
		PH_DRAIN   = 7'b1000000
	} phase_t;

	// Wire types that the parser understands.
	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LENGTH  = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	localparam int FN_W    = 61;
	localparam int VAL_W   = 64;
	localparam int CNT_W   = 4;

	// Last varint byte index before an overflow is declared.
	localparam logic [CNT_W-1:0] VARINT_LAST_IDX = 4'd9;
	localparam logic [CNT_W-1:0] FIX64_BYTES     = 4'd8;
	localparam logic [CNT_W-1:0] FIX32_BYTES     = 4'd4;

endpackage

`default_nettype wire

// File: rtl/protobuf_wire_field_parser.sv
`default_nettype none

// Protocol buffer wire-format parser, one nesting level. Each request carries one byte of a
// message buffer and a mark on its final byte. The parser reads a varint tag, splits it into a
// field number and a wire type, then reads a varint, a little-endian 64-bit or 32-bit fixed
// value, or a length followed by that many payload bytes, which are streamed out one per
// result. Each byte gives at most one result. Throughput is one byte per clock unless the
// result register is held by a stalled consumer: a byte is captured in an input register and
// decoded by one shallow pass (a 7-bit or 8-bit merge into the 64-bit accumulator and a 64-bit
// decrement of the payload count) that writes the result register. The input side stalls only
// when a byte that yields a result finds the result register still held by a stalled consumer.
// After the last byte of a buffer all parser state returns to its reset value, so the next
// buffer may follow in the very next cycle. Errors (varint overflow, short fixed value, short
// payload) and unknown wire types silence the parser until the end of the buffer, where an
// end result is emitted unless the error or unknown result fell on the final byte itself;
// payload bytes sent before a short-payload error must be discarded by the consumer.
module protobuf_wire_field_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Byte request channel.
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        buffer_last,
	// Result channel.
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       kind,
	output logic [60:0]      field_id,
	output logic [2:0]       wire_code,
	output logic [63:0]      value,
	output logic [7:0]       payload_byte,
	output logic             payload_last,
	output logic             buffer_end,
	output logic [2:0]       error_code
);

	// Input register.
	logic       item_valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state.
	pbwfp_pkg::phase_t                    phase_q;
	logic [pbwfp_pkg::VAL_W-1:0]          acc_q;
	logic [pbwfp_pkg::CNT_W-1:0]          cnt_q;
	logic [pbwfp_pkg::FN_W-1:0]           held_fn_q;
	logic [2:0]                           held_wt_q;
	logic [pbwfp_pkg::VAL_W-1:0]          remain_q;

	// Result register.
	logic                                 res_valid_s2;
	pbwfp_pkg::kind_t                     res_kind_s2;
	logic [pbwfp_pkg::FN_W-1:0]           res_fn_s2;
	logic [2:0]                           res_wt_s2;
	logic [pbwfp_pkg::VAL_W-1:0]          res_value_s2;
	logic [7:0]                           res_pbyte_s2;
	logic                                 res_plast_s2;
	logic                                 res_bend_s2;
	pbwfp_pkg::err_t                      res_err_s2;

	// Next-state and result values of the decode pass.
	pbwfp_pkg::phase_t                    nx_phase;
	logic [pbwfp_pkg::VAL_W-1:0]          nx_acc;
	logic [pbwfp_pkg::CNT_W-1:0]          nx_cnt;
	logic [pbwfp_pkg::FN_W-1:0]           nx_fn;
	logic [2:0]                           nx_wt;
	logic [pbwfp_pkg::VAL_W-1:0]          nx_remain;
	logic                                 has_res;
	pbwfp_pkg::kind_t                     nx_kind;
	logic [pbwfp_pkg::VAL_W-1:0]          nx_value;
	logic [7:0]                           nx_pbyte;
	logic                                 nx_plast;
	pbwfp_pkg::err_t                      nx_err;

	// Varint and fixed merges of the current byte into the accumulator.
	logic [6:0]                           shamt_var;
	logic [pbwfp_pkg::VAL_W-1:0]          vacc;
	logic                                 v_more;
	logic                                 v_ovf;
	logic [pbwfp_pkg::VAL_W-1:0]          facc;
	logic [pbwfp_pkg::CNT_W-1:0]          fcnt;
	logic [pbwfp_pkg::CNT_W-1:0]          fneed;
	logic [pbwfp_pkg::VAL_W-1:0]          remain_dec;

	logic advance;

	// A byte moves on when it yields no result or the result register can take one.
	assign advance    = item_valid_s1 && (!has_res || !res_valid_s2 || !result_stall);
	assign data_stall = item_valid_s1 && !advance;

	// Bits beyond 63 of a shifted varint group fall off, so only bit 0 of a tenth byte lands.
	assign shamt_var = 7'({3'b000, cnt_q} * 7);
	assign vacc      = acc_q | (64'({57'd0, byte_s1[6:0]}) << shamt_var);
	assign v_more    = byte_s1[7];
	assign v_ovf     = v_more && (cnt_q >= pbwfp_pkg::VARINT_LAST_IDX);

	assign facc  = cnt_q[3] ? acc_q
	                        : (acc_q | (64'({56'd0, byte_s1}) << {cnt_q[2:0], 3'b000}));
	assign fcnt  = cnt_q + 4'd1;
	assign fneed = (phase_q == pbwfp_pkg::PH_FIX64) ? pbwfp_pkg::FIX64_BYTES
	                                                : pbwfp_pkg::FIX32_BYTES;

	assign remain_dec = (remain_q != '0) ? (remain_q - 64'd1) : remain_q;

	always_comb begin
		nx_phase  = phase_q;
		nx_acc    = acc_q;
		nx_cnt    = cnt_q;
		nx_fn     = held_fn_q;
		nx_wt     = held_wt_q;
		nx_remain = remain_q;
		has_res   = 1'b0;
		nx_kind   = pbwfp_pkg::KIND_SCALAR;
		nx_value  = '0;
		nx_pbyte  = '0;
		nx_plast  = 1'b0;
		nx_err    = pbwfp_pkg::ERR_NONE;

		case (phase_q)
			pbwfp_pkg::PH_TAG: begin
				if (v_ovf) begin
					nx_fn    = '0;
					nx_wt    = '0;
					has_res  = 1'b1;
					nx_kind  = pbwfp_pkg::KIND_ERROR;
					nx_err   = pbwfp_pkg::ERR_VARINT_OVF;
					nx_phase = pbwfp_pkg::PH_DRAIN;
					nx_acc   = '0;
					nx_cnt   = '0;
				end else if (v_more && !last_s1) begin
					nx_acc = vacc;
					nx_cnt = cnt_q + 4'd1;
				end else begin
					// Tag complete, or cut short by the buffer end: split it.
					nx_fn  = vacc[63:3];
					nx_wt  = vacc[2:0];
					nx_acc = '0;
					nx_cnt = '0;
					case (vacc[2:0])
						pbwfp_pkg::WT_VARINT: begin
							if (last_s1) begin
								has_res = 1'b1;
								nx_kind = pbwfp_pkg::KIND_SCALAR;
							end else begin
								nx_phase = pbwfp_pkg::PH_VAL;
							end
						end
						pbwfp_pkg::WT_FIXED64: begin
							if (last_s1) begin
								has_res  = 1'b1;
								nx_kind  = pbwfp_pkg::KIND_ERROR;
								nx_err   = pbwfp_pkg::ERR_SHORT_FIX64;
								nx_phase = pbwfp_pkg::PH_DRAIN;
							end else begin
								nx_phase = pbwfp_pkg::PH_FIX64;
							end
						end
						pbwfp_pkg::WT_LENGTH: begin
							if (last_s1) begin
								has_res = 1'b1;
								nx_kind = pbwfp_pkg::KIND_LEN_HDR;
							end else begin
								nx_phase = pbwfp_pkg::PH_LEN;
							end
						end
						pbwfp_pkg::WT_FIXED32: begin
							if (last_s1) begin
								has_res  = 1'b1;
								nx_kind  = pbwfp_pkg::KIND_ERROR;
								nx_err   = pbwfp_pkg::ERR_SHORT_FIX32;
								nx_phase = pbwfp_pkg::PH_DRAIN;
							end else begin
								nx_phase = pbwfp_pkg::PH_FIX32;
							end
						end
						default: begin
							has_res  = 1'b1;
							nx_kind  = pbwfp_pkg::KIND_UNKNOWN;
							nx_phase = pbwfp_pkg::PH_DRAIN;
						end
					endcase
				end
			end
			pbwfp_pkg::PH_VAL: begin
				if (v_ovf) begin
					has_res  = 1'b1;
					nx_kind  = pbwfp_pkg::KIND_ERROR;
					nx_err   = pbwfp_pkg::ERR_VARINT_OVF;
					nx_phase = pbwfp_pkg::PH_DRAIN;
					nx_acc   = '0;
					nx_cnt   = '0;
				end else if (!v_more || last_s1) begin
					has_res  = 1'b1;
					nx_kind  = pbwfp_pkg::KIND_SCALAR;
					nx_value = vacc;
					nx_phase = pbwfp_pkg::PH_TAG;
					nx_acc   = '0;
					nx_cnt   = '0;
				end else begin
					nx_acc = vacc;
					nx_cnt = cnt_q + 4'd1;
				end
			end
			pbwfp_pkg::PH_FIX64, pbwfp_pkg::PH_FIX32: begin
				if (fcnt >= fneed) begin
					has_res  = 1'b1;
					nx_kind  = pbwfp_pkg::KIND_SCALAR;
					nx_value = facc;
					nx_phase = pbwfp_pkg::PH_TAG;
					nx_acc   = '0;
					nx_cnt   = '0;
				end else if (last_s1) begin
					has_res  = 1'b1;
					nx_kind  = pbwfp_pkg::KIND_ERROR;
					nx_err   = (phase_q == pbwfp_pkg::PH_FIX64) ? pbwfp_pkg::ERR_SHORT_FIX64
					                                            : pbwfp_pkg::ERR_SHORT_FIX32;
					nx_phase = pbwfp_pkg::PH_DRAIN;
					nx_acc   = '0;
					nx_cnt   = '0;
				end else begin
					nx_acc = facc;
					nx_cnt = fcnt;
				end
			end
			pbwfp_pkg::PH_LEN: begin
				if (v_ovf) begin
					has_res  = 1'b1;
					nx_kind  = pbwfp_pkg::KIND_ERROR;
					nx_err   = pbwfp_pkg::ERR_VARINT_OVF;
					nx_phase = pbwfp_pkg::PH_DRAIN;
					nx_acc   = '0;
					nx_cnt   = '0;
				end else if (v_more && !last_s1) begin
					nx_acc = vacc;
					nx_cnt = cnt_q + 4'd1;
				end else begin
					nx_acc  = '0;
					nx_cnt  = '0;
					has_res = 1'b1;
					if (vacc == '0) begin
						// An empty payload closes the field at once.
						nx_kind  = pbwfp_pkg::KIND_LEN_HDR;
						nx_phase = pbwfp_pkg::PH_TAG;
					end else if (last_s1) begin
						nx_kind  = pbwfp_pkg::KIND_ERROR;
						nx_err   = pbwfp_pkg::ERR_SHORT_PAYLD;
						nx_phase = pbwfp_pkg::PH_DRAIN;
					end else begin
						nx_kind   = pbwfp_pkg::KIND_LEN_HDR;
						nx_value  = vacc;
						nx_remain = vacc;
						nx_phase  = pbwfp_pkg::PH_PAYLOAD;
					end
				end
			end
			pbwfp_pkg::PH_PAYLOAD: begin
				nx_remain = remain_dec;
				has_res   = 1'b1;
				if ((remain_dec != '0) && last_s1) begin
					nx_kind  = pbwfp_pkg::KIND_ERROR;
					nx_err   = pbwfp_pkg::ERR_SHORT_PAYLD;
					nx_phase = pbwfp_pkg::PH_DRAIN;
					nx_acc   = '0;
					nx_cnt   = '0;
				end else begin
					nx_kind  = pbwfp_pkg::KIND_PAYLOAD;
					nx_pbyte = byte_s1;
					nx_plast = (remain_dec == '0);
					if (remain_dec == '0) begin
						nx_phase = pbwfp_pkg::PH_TAG;
					end
				end
			end
			default: begin
				// Draining after an error or unknown wire type.
				if (last_s1) begin
					nx_fn   = '0;
					nx_wt   = '0;
					has_res = 1'b1;
					nx_kind = pbwfp_pkg::KIND_END;
				end
			end
		endcase
	end

	// Input register: refilled whenever the held byte moves on or none is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			item_valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= buffer_last;
		end
	end

	// Parser state: the final byte of a buffer returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pbwfp_pkg::PH_TAG;
			acc_q     <= '0;
			cnt_q     <= '0;
			held_fn_q <= '0;
			held_wt_q <= '0;
			remain_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q   <= pbwfp_pkg::PH_TAG;
				acc_q     <= '0;
				cnt_q     <= '0;
				held_fn_q <= '0;
				held_wt_q <= '0;
				remain_q  <= '0;
			end else begin
				phase_q   <= nx_phase;
				acc_q     <= nx_acc;
				cnt_q     <= nx_cnt;
				held_fn_q <= nx_fn;
				held_wt_q <= nx_wt;
				remain_q  <= nx_remain;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && has_res) begin
			res_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_kind_s2  <= nx_kind;
			res_fn_s2    <= nx_fn;
			res_wt_s2    <= nx_wt;
			res_value_s2 <= nx_value;
			res_pbyte_s2 <= nx_pbyte;
			res_plast_s2 <= nx_plast;
			res_bend_s2  <= last_s1;
			res_err_s2   <= nx_err;
		end
	end

	assign result_valid = res_valid_s2;
	assign kind         = res_kind_s2;
	assign field_id     = res_fn_s2;
	assign wire_code    = res_wt_s2;
	assign value        = res_value_s2;
	assign payload_byte = res_pbyte_s2;
	assign payload_last = res_plast_s2;
	assign buffer_end   = res_bend_s2;
	assign error_code   = res_err_s2;

`ifndef NO_ASSERTIONS
	// The last byte of a buffer leaves the parser fully reset.
	a_buffer_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (phase_q == pbwfp_pkg::PH_TAG && acc_q == '0 &&
		                          cnt_q == '0 && remain_q == '0))
		else $error("parser state not cleared after buffer end");

	// The varint byte count never passes the overflow point.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pbwfp_pkg::VARINT_LAST_IDX)
		else $error("varint byte count out of range");

	// Error results carry a code and no value; other results carry no code.
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> ((res_kind_s2 == pbwfp_pkg::KIND_ERROR) ?
		                  (res_err_s2 != pbwfp_pkg::ERR_NONE && res_value_s2 == '0) :
		                  (res_err_s2 == pbwfp_pkg::ERR_NONE)))
		else $error("error code and result kind disagree");

	// The input side stalls only while a byte is held and blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> (item_valid_s1 && has_res && res_valid_s2 && result_stall))
		else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
